// ===== rtl/up_down_counter_wrap_clamp_core_macros.svh =====
// assertion helpers shared by the counter modules
`ifndef UP_DOWN_COUNTER_WRAP_CLAMP_CORE_MACROS_SVH
`define UP_DOWN_COUNTER_WRAP_CLAMP_CORE_MACROS_SVH

// same-cycle implication
`define UDCWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UDCWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/udcwc_pkg.sv =====
`default_nettype none

package udcwc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SUM_W       = VALUE_WIDTH + 2;
  localparam int DIFF_W      = VALUE_WIDTH + 3;
  localparam int RANGE_W     = VALUE_WIDTH + 1;
  localparam int CNT_W       = $clog2(DIFF_W + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_MODE   = CFG_IDX_W'(5);

  localparam logic signed [VALUE_WIDTH-1:0] MIN_RESET  = '0;
  localparam logic signed [VALUE_WIDTH-1:0] MAX_RESET  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] STEP_RESET = VALUE_WIDTH'(1);
  localparam logic signed [VALUE_WIDTH-1:0] INIT_RESET = '0;

  typedef enum logic [1:0] {
    ACT_TRIGGER,
    ACT_SET,
    ACT_INC,
    ACT_DEC
  } action_t;

  typedef struct packed {
    action_t                        action;
    logic                           inc_level;
    logic                           dec_level;
    logic                           clear_level;
    logic signed [VALUE_WIDTH-1:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  count_value;
    logic                           at_minimum;
    logic                           at_maximum;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0]  lower_limit;
    logic signed [VALUE_WIDTH-1:0]  upper_limit;
    logic signed [VALUE_WIDTH-1:0]  step_size;
    logic signed [VALUE_WIDTH-1:0]  start_value;
    logic                           wrap_enable;
    logic                           rise_mode;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic signed [DIFF_W-1:0]  dividend;
    logic [RANGE_W-1:0]        divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [RANGE_W-1:0]  rem;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_OP,
    SEQ_LIM,
    SEQ_MOD,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    MOD_IDLE,
    MOD_ABS,
    MOD_RUN,
    MOD_FIX,
    MOD_DONE
  } mod_state_t;

endpackage

`default_nettype wire

// ===== rtl/udcwc_mod.sv =====
`default_nettype none
`include "up_down_counter_wrap_clamp_core_macros.svh"

module udcwc_mod (
  input  logic                clk,
  input  logic                rst,
  input  udcwc_pkg::mod_req_t req,
  output udcwc_pkg::mod_rsp_t rsp
);
  import udcwc_pkg::*;

  mod_state_t               state, state_next;
  logic signed [DIFF_W-1:0] dividend;
  logic [DIFF_W-1:0]        mag;
  logic [RANGE_W-1:0]       divisor;
  logic [RANGE_W-1:0]       rem;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic [RANGE_W:0]         trial;
  logic [RANGE_W:0]         trial_sub;
  logic                     trial_ge;

  // one restoring step per cycle
  assign trial     = {rem, mag[DIFF_W-1]};
  assign trial_ge  = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      MOD_IDLE: if (req.start) state_next = MOD_ABS;
      MOD_ABS:  state_next = MOD_RUN;
      MOD_RUN:  if (cnt == CNT_W'(1)) state_next = MOD_FIX;
      MOD_FIX:  state_next = MOD_DONE;
      MOD_DONE: state_next = MOD_IDLE;
      default:  state_next = MOD_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == MOD_DONE);
    rsp.rem  = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MOD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MOD_IDLE: begin
        if (req.start) begin
          dividend <= req.dividend;
          divisor  <= req.divisor;
        end
      end
      MOD_ABS: begin
        neg <= dividend[DIFF_W-1];
        mag <= dividend[DIFF_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
        rem <= '0;
        cnt <= CNT_W'(DIFF_W);
      end
      MOD_RUN: begin
        rem <= trial_ge ? trial_sub[RANGE_W-1:0] : trial[RANGE_W-1:0];
        mag <= mag << 1;
        cnt <= cnt - CNT_W'(1);
      end
      MOD_FIX: begin
        // floored remainder for a negative offset
        if (neg && rem != '0) rem <= divisor - rem;
      end
      default: begin
      end
    endcase
  end

  `UDCWC_ASSERT_IMP(a_rem_below_divisor, clk, rst, rsp.done, rem < divisor, "remainder not below range")
  `UDCWC_ASSERT_IMP(a_divisor_nonzero, clk, rst, req.start, req.divisor != '0, "started with zero range")
  `UDCWC_ASSERT_NEXT(a_last_step_fix, clk, rst, state == MOD_RUN && cnt == CNT_W'(1), state == MOD_FIX, "step count overrun")

endmodule

`default_nettype wire

// ===== rtl/udcwc_seq.sv =====
`default_nettype none
`include "up_down_counter_wrap_clamp_core_macros.svh"

module udcwc_seq (
  input  logic                                   clk,
  input  logic                                   rst,
  input  udcwc_pkg::cfg_t                        cfg,
  input  udcwc_pkg::in_item_t                    item,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  output udcwc_pkg::mod_req_t                    mreq,
  input  udcwc_pkg::mod_rsp_t                    mrsp,
  output logic                                   fin,
  output logic signed [udcwc_pkg::VALUE_WIDTH-1:0] count_value,
  input  logic                                   take
);
  import udcwc_pkg::*;

  seq_state_t                    state, state_next;
  logic signed [VALUE_WIDTH-1:0] count;
  logic signed [VALUE_WIDTH-1:0] load_q;
  logic                          prev_inc, prev_dec, prev_reset;
  logic                          pend_load, pend_inc, pend_dec;
  logic signed [SUM_W-1:0]       v_q;
  logic signed [SUM_W-1:0]       range_q;

  logic                          edge_on, rst_fire, inc_fire, dec_fire, any_pend;
  logic signed [SUM_W-1:0]       count_ext, step_ext, lo_ext, hi_ext, addend, sum;
  logic signed [SUM_W-1:0]       v_next, range_next, wrap_sum;
  logic signed [DIFF_W-1:0]      diff;
  logic                          op_sub, range_pos, use_mod;
  logic                          below, above, lo_gt_hi;
  logic signed [VALUE_WIDTH-1:0] clamp_val, lim_val;

  // trigger decode at transfer
  assign edge_on  = cfg.rise_mode;
  assign rst_fire = item.clear_level & (~edge_on | ~prev_reset);
  assign inc_fire = item.inc_level & (~edge_on | ~prev_inc);
  assign dec_fire = item.dec_level & (~edge_on | ~prev_dec);
  assign any_pend = pend_load | pend_inc | pend_dec;

  assign count_ext = SUM_W'(count);
  assign step_ext  = SUM_W'(cfg.step_size);
  assign lo_ext    = SUM_W'(cfg.lower_limit);
  assign hi_ext    = SUM_W'(cfg.upper_limit);

  // shared add/sub for the step
  assign op_sub     = ~pend_inc;
  assign addend     = op_sub ? ~step_ext : step_ext;
  assign sum        = count_ext + addend + SUM_W'(op_sub);
  assign v_next     = pend_load ? SUM_W'(load_q) : sum;
  assign range_next = hi_ext - lo_ext + SUM_W'(1);

  assign range_pos = ~range_q[SUM_W-1] && (range_q != '0);
  assign use_mod   = cfg.wrap_enable && range_pos;
  assign diff      = DIFF_W'(v_q) - DIFF_W'(lo_ext);

  assign below     = v_q < lo_ext;
  assign above     = v_q > hi_ext;
  assign lo_gt_hi  = cfg.lower_limit > cfg.upper_limit;
  assign clamp_val = below ? (lo_gt_hi ? cfg.upper_limit : cfg.lower_limit)
                           : (above ? cfg.upper_limit : v_q[VALUE_WIDTH-1:0]);
  assign lim_val   = cfg.wrap_enable ? v_q[VALUE_WIDTH-1:0] : clamp_val;

  assign wrap_sum  = lo_ext + SUM_W'(mrsp.rem);

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (item_valid) state_next = SEQ_OP;
      SEQ_OP:   state_next = any_pend ? SEQ_LIM : SEQ_DONE;
      SEQ_LIM:  state_next = use_mod ? SEQ_MOD : SEQ_OP;
      SEQ_MOD:  if (mrsp.done) state_next = SEQ_OP;
      SEQ_DONE: if (take) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    item_stall    = (state != SEQ_IDLE);
    fin           = (state == SEQ_DONE);
    mreq.start    = (state == SEQ_LIM) && use_mod;
    mreq.dividend = diff;
    mreq.divisor  = range_q[RANGE_W-1:0];
  end

  assign count_value = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= INIT_RESET;
      prev_inc   <= 1'b0;
      prev_dec   <= 1'b0;
      prev_reset <= 1'b0;
      pend_load  <= 1'b0;
      pend_inc   <= 1'b0;
      pend_dec   <= 1'b0;
    end else begin
      unique case (state)
        SEQ_IDLE: begin
          if (item_valid) begin
            load_q <= item.load_value;
            unique case (item.action)
              ACT_TRIGGER: begin
                if (edge_on) prev_reset <= item.clear_level;
                if (rst_fire) begin
                  count <= cfg.start_value;
                end else begin
                  prev_inc <= item.inc_level;
                  prev_dec <= item.dec_level;
                  pend_inc <= inc_fire;
                  pend_dec <= dec_fire;
                end
              end
              ACT_SET: pend_load <= 1'b1;
              ACT_INC: pend_inc  <= 1'b1;
              ACT_DEC: pend_dec  <= 1'b1;
              default: begin
              end
            endcase
          end
        end
        SEQ_OP: begin
          if (any_pend) begin
            v_q     <= v_next;
            range_q <= range_next;
            priority if (pend_load) pend_load <= 1'b0;
            else if (pend_inc)      pend_inc  <= 1'b0;
            else                    pend_dec  <= 1'b0;
          end
        end
        SEQ_LIM: begin
          if (!use_mod) count <= lim_val;
        end
        SEQ_MOD: begin
          if (mrsp.done) count <= wrap_sum[VALUE_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  `UDCWC_ASSERT_NEXT(a_transfer_starts_work, clk, rst, state == SEQ_IDLE && item_valid, state == SEQ_OP, "transfer did not start work")
  `UDCWC_ASSERT_IMP(a_mod_done_in_wait, clk, rst, mrsp.done, state == SEQ_MOD, "remainder ready outside wait")
  `UDCWC_ASSERT_IMP(a_nothing_pending_at_end, clk, rst, fin, !(pend_load || pend_inc || pend_dec), "result with steps pending")

endmodule

`default_nettype wire

// ===== rtl/up_down_counter_wrap_clamp_core.sv =====
// an item passes OP, then LIM per clamped or truncated limit step, LIM and MOD per wrapped
// step (35-step remainder unit), at most two steps, then DONE; result register loads at the end
// one item in flight; the next transfer is taken once the result sits in the output register
// wrapped steps wait on the single shared remainder unit
// rst (sync, active high): registers to defaults, counter to zero, edge history cleared
`default_nettype none

module up_down_counter_wrap_clamp_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  udcwc_pkg::in_item_t                   item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output udcwc_pkg::out_item_t                  result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [udcwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [udcwc_pkg::VALUE_WIDTH-1:0]     cfg_data
);
  import udcwc_pkg::*;

  cfg_t                          cfg;
  mod_req_t                      mreq;
  mod_rsp_t                      mrsp;
  logic                          fin, take;
  logic signed [VALUE_WIDTH-1:0] count_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_limit <= MIN_RESET;
      cfg.upper_limit <= MAX_RESET;
      cfg.step_size   <= STEP_RESET;
      cfg.start_value <= INIT_RESET;
      cfg.wrap_enable <= 1'b0;
      cfg.rise_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOWER_LIMIT: cfg.lower_limit <= cfg_data;
        CFG_UPPER_LIMIT: cfg.upper_limit <= cfg_data;
        CFG_STEP_SIZE:   cfg.step_size   <= cfg_data;
        CFG_START_VALUE: cfg.start_value <= cfg_data;
        CFG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        CFG_RISE_MODE:   cfg.rise_mode   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  udcwc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mreq        (mreq),
    .mrsp        (mrsp),
    .fin         (fin),
    .count_value (count_value),
    .take        (take)
  );

  udcwc_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // output register
  assign take = fin && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.count_value <= count_value;
      result.at_minimum  <= (count_value <= cfg.lower_limit);
      result.at_maximum  <= (count_value >= cfg.upper_limit);
    end
  end

endmodule

`default_nettype wire
